// File: sv/hgs_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Hysteresis gait selector package
// Types, activity codes, register indexes and reset values shared by the
// gait selector modules.
// ----------------------------------------------------------------------------
package hgs_pkg;

   localparam int ActWidth   = 4;
   localparam int SpeedWidth = 16;
   localparam int TurnWidth  = 16;
   localparam int StepWidth  = 16;
   localparam int DwellWidth = 32;
   localparam int CsrIdxWidth  = 3;
   localparam int CsrDataWidth = 32;

   typedef logic [ActWidth-1:0] hgs_act_type;

   typedef enum logic [1:0] {
      GAIT_IDLE = 2'd0,
      GAIT_WALK = 2'd1,
      GAIT_RUN  = 2'd2,
      GAIT_TURN = 2'd3
   } hgs_gait_type;

   localparam hgs_act_type ACT_TURN = 4'd3;

   localparam logic [CsrIdxWidth-1:0] CSR_MOVE_ENTER     = 3'd0;
   localparam logic [CsrIdxWidth-1:0] CSR_MOVE_EXIT      = 3'd1;
   localparam logic [CsrIdxWidth-1:0] CSR_RUN_ENTER      = 3'd2;
   localparam logic [CsrIdxWidth-1:0] CSR_RUN_EXIT       = 3'd3;
   localparam logic [CsrIdxWidth-1:0] CSR_TURN_THRESHOLD = 3'd4;
   localparam logic [CsrIdxWidth-1:0] CSR_MIN_DWELL      = 3'd5;

   localparam logic [SpeedWidth-1:0] MOVE_ENTER_RESET     = 16'd128;
   localparam logic [SpeedWidth-1:0] MOVE_EXIT_RESET      = 16'd64;
   localparam logic [SpeedWidth-1:0] RUN_ENTER_RESET      = 16'd768;
   localparam logic [SpeedWidth-1:0] RUN_EXIT_RESET       = 16'd640;
   localparam logic [SpeedWidth-1:0] TURN_THRESHOLD_RESET = 16'd64;
   localparam logic [DwellWidth-1:0] MIN_DWELL_RESET      = 32'd16384;

   typedef struct packed {
      logic [SpeedWidth-1:0] move_enter;
      logic [SpeedWidth-1:0] move_exit;
      logic [SpeedWidth-1:0] run_enter;
      logic [SpeedWidth-1:0] run_exit;
      logic [SpeedWidth-1:0] turn_threshold;
      logic [DwellWidth-1:0] min_dwell;
   } hgs_cfg_type;

   typedef struct packed {
      hgs_act_type            proposed;
      logic [SpeedWidth-1:0]  speed;
      logic [TurnWidth-1:0]   turn_rate;
      logic [StepWidth-1:0]   time_step;
   } hgs_item_type;

endpackage
`default_nettype wire

// File: sv/hgs_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Gait selector core
// Holds the gait state, dwell timer and hysteresis flags, and works out the
// chosen activity for one item; the state moves on when advance is high.
// ----------------------------------------------------------------------------
module hgs_core (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 advance,
   input  wire hgs_pkg::hgs_item_type item,
   input  wire hgs_pkg::hgs_cfg_type  cfg,
   output hgs_pkg::hgs_act_type       chosen
);
   import hgs_pkg::*;

   hgs_gait_type          gait_ff, gait_in;
   logic [DwellWidth-1:0] dwell_ff, dwell_in;
   logic                  changed_ff, changed_in;
   logic                  moving_ff, moving_in;
   logic                  running_ff, running_in;

   logic [DwellWidth:0]   dwell_sum;
   logic [DwellWidth-1:0] dwell_sat;
   logic [TurnWidth:0]    turn_mag;
   hgs_gait_type          wanted;
   logic                  do_change;

   always_comb begin
      dwell_sum = {1'b0, dwell_ff} + {{(DwellWidth-StepWidth+1){1'b0}}, item.time_step};
      dwell_sat = dwell_sum[DwellWidth] ? {DwellWidth{1'b1}} : dwell_sum[DwellWidth-1:0];

      moving_in  = item.speed > (moving_ff ? cfg.move_exit : cfg.move_enter);
      running_in = moving_in && (item.speed > (running_ff ? cfg.run_exit : cfg.run_enter));

      if (item.turn_rate[TurnWidth-1]) begin
         turn_mag = (TurnWidth+1)'(1 << TurnWidth) - {1'b0, item.turn_rate};
      end else begin
         turn_mag = {1'b0, item.turn_rate};
      end

      if (moving_in) begin
         wanted = running_in ? GAIT_RUN : GAIT_WALK;
      end else if (turn_mag > {1'b0, cfg.turn_threshold}) begin
         wanted = GAIT_TURN;
      end else begin
         wanted = GAIT_IDLE;
      end

      do_change = (wanted != gait_ff) && !(changed_ff && (dwell_sat < cfg.min_dwell));

      gait_in    = gait_ff;
      dwell_in   = dwell_sat;
      changed_in = changed_ff;
      if (item.proposed > ACT_TURN) begin
         chosen = item.proposed;
      end else begin
         if (do_change) begin
            gait_in    = wanted;
            dwell_in   = '0;
            changed_in = 1'b1;
         end
         chosen = {{(ActWidth-2){1'b0}}, gait_in};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gait_ff    <= GAIT_IDLE;
         dwell_ff   <= '0;
         changed_ff <= 1'b0;
         moving_ff  <= 1'b0;
         running_ff <= 1'b0;
      end else if (advance) begin
         gait_ff    <= gait_in;
         dwell_ff   <= dwell_in;
         changed_ff <= changed_in;
         moving_ff  <= moving_in;
         running_ff <= running_in;
      end
   end

   // A body can only be running while it is moving.
   assert property (@(posedge clock) disable iff (reset) running_ff |-> moving_ff)
      else $error("running flag set without moving flag");

   // Once a change has been taken, the first-change exemption never returns.
   assert property (@(posedge clock) disable iff (reset) changed_ff |=> changed_ff)
      else $error("change flag cleared outside reset");

   // State only moves when an item advances.
   assert property (@(posedge clock) disable iff (reset)
      !advance |=> ($stable(gait_ff) && $stable(dwell_ff) && $stable(moving_ff)))
      else $error("gait state changed without an item");

   // A gait change always restarts the dwell timer.
   assert property (@(posedge clock) disable iff (reset)
      (advance && (gait_in != gait_ff)) |=> (dwell_ff == '0))
      else $error("gait changed without clearing the dwell timer");

endmodule
`default_nettype wire

// File: sv/hysteresis_gait_selector.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Hysteresis gait selector
// Picks an activity per item from a proposed code, speed and turn rate, with
// hysteresis on the moving and running decisions and a minimum dwell time.
//
// Usage:
//   Items enter on the req_ channel and one result per item leaves on the
//   rsp_ channel; both use valid and stall. An item is taken into an input
//   register; its result moves into the result register once that register
//   is free, and is shown there until the receiver takes it.
//   Throughput is one item per cycle while the receiver does not stall; the
//   gait and timer state is updated when an item moves from the input
//   register to the result register.
//   When the receiver stalls, the result holds and one further item can be
//   held in the input register; req_stall rises after that.
//   Thresholds and the minimum dwell are written through the csr_ port while
//   the block is idle, a user rule the block does not enforce. Reset restores
//   defaults, idles the gait, clears timer and flags, empties both registers.
// ----------------------------------------------------------------------------
module hysteresis_gait_selector (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output      logic                                req_stall,
   input  wire logic [3:0]                          req_proposed,
   input  wire logic [15:0]                         req_speed,
   input  wire logic signed [15:0]                  req_turn_rate,
   input  wire logic [15:0]                         req_time_step,
   output      logic                                rsp_valid,
   input  wire logic                                rsp_stall,
   output      logic [3:0]                          rsp_chosen_activity,
   input  wire logic                                csr_write_enable,
   input  wire logic [hgs_pkg::CsrIdxWidth-1:0]     csr_index,
   input  wire logic [hgs_pkg::CsrDataWidth-1:0]    csr_write_data
);
   import hgs_pkg::*;

   hgs_cfg_type  cfg_ff;
   hgs_item_type item_ff;
   logic         item_valid_ff;
   logic         rsp_valid_ff;
   hgs_act_type  rsp_act_ff;
   hgs_act_type  chosen;
   logic         out_free;
   logic         advance;
   logic         req_take;

   always_comb begin
      out_free  = !rsp_valid_ff || !rsp_stall;
      advance   = item_valid_ff && out_free;
      req_stall = item_valid_ff && !out_free;
      req_take  = req_valid && !req_stall;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.move_enter     <= MOVE_ENTER_RESET;
         cfg_ff.move_exit      <= MOVE_EXIT_RESET;
         cfg_ff.run_enter      <= RUN_ENTER_RESET;
         cfg_ff.run_exit       <= RUN_EXIT_RESET;
         cfg_ff.turn_threshold <= TURN_THRESHOLD_RESET;
         cfg_ff.min_dwell      <= MIN_DWELL_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_MOVE_ENTER:     cfg_ff.move_enter     <= csr_write_data[SpeedWidth-1:0];
            CSR_MOVE_EXIT:      cfg_ff.move_exit      <= csr_write_data[SpeedWidth-1:0];
            CSR_RUN_ENTER:      cfg_ff.run_enter      <= csr_write_data[SpeedWidth-1:0];
            CSR_RUN_EXIT:       cfg_ff.run_exit       <= csr_write_data[SpeedWidth-1:0];
            CSR_TURN_THRESHOLD: cfg_ff.turn_threshold <= csr_write_data[SpeedWidth-1:0];
            CSR_MIN_DWELL:      cfg_ff.min_dwell      <= csr_write_data[DwellWidth-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (req_take) begin
            item_valid_ff <= 1'b1;
         end else if (advance) begin
            item_valid_ff <= 1'b0;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (out_free) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         item_ff.proposed  <= req_proposed;
         item_ff.speed     <= req_speed;
         item_ff.turn_rate <= req_turn_rate;
         item_ff.time_step <= req_time_step;
      end
      if (advance) begin
         rsp_act_ff <= chosen;
      end
   end

   hgs_core u_core (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .item    (item_ff),
      .cfg     (cfg_ff),
      .chosen  (chosen)
   );

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_chosen_activity = rsp_act_ff;

   // An accepted item is always held in the input register on the next cycle.
   assert property (@(posedge clock) disable iff (reset) req_take |=> item_valid_ff)
      else $error("accepted item lost");

   // A held item that cannot advance keeps its payload.
   assert property (@(posedge clock) disable iff (reset)
      (item_valid_ff && !advance) |=> (item_valid_ff && $stable(item_ff)))
      else $error("held item changed while stalled");

   // An item advances only into a result register that is free.
   assert property (@(posedge clock) disable iff (reset)
      advance |-> (!rsp_valid_ff || !rsp_stall))
      else $error("result overwritten while stalled");

endmodule
`default_nettype wire
